/* hw/rtl/wsh_pkg.sv */
// Package: widths, pipeline depth and the per-stage axis record for the size-hint fit block.
package wsh_pkg;

    localparam int DIM_W      = 16;              // pixel dimension width
    localparam int DECO_W     = 10;              // decoration width (up to 2*255)
    localparam int DIV_STEPS  = DIM_W;           // one quotient bit per divider stage
    localparam int PIPE_DEPTH = DIV_STEPS + 4;   // clamp, offset, divider, sum, output
    localparam int SUM_W      = DIM_W + 2;       // base + offset + step adjust

    // Payload carried down one axis pipeline
    typedef struct packed {
        logic [DIM_W-1:0]  v;      // clamped client size
        logic [DIM_W-1:0]  r;      // size above base
        logic [DIM_W-1:0]  dvd;    // dividend bits not yet consumed
        logic [DIM_W-1:0]  rem;    // partial remainder
        logic [SUM_W-1:0]  s;      // rounded-up size
        logic [DIM_W-1:0]  mn;
        logic [DIM_W-1:0]  mx;
        logic [DIM_W-1:0]  step;
        logic [DIM_W-1:0]  base;
        logic [DECO_W-1:0] deco;
    } axis_stage_t;

endpackage

/* hw/rtl/wsh_axis.sv */
// One axis of the size-hint fit: clamp, pipelined remainder divider, round up, step down, saturate.
module wsh_axis
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [wsh_pkg::DIM_W-1:0]  frame,
    input  logic [wsh_pkg::DECO_W-1:0] deco,
    input  logic [wsh_pkg::DIM_W-1:0]  mn,
    input  logic [wsh_pkg::DIM_W-1:0]  mx,
    input  logic [wsh_pkg::DIM_W-1:0]  step,
    input  logic [wsh_pkg::DIM_W-1:0]  base,
    output logic [wsh_pkg::DIM_W-1:0]  result
);

    localparam int NREG = wsh_pkg::DIV_STEPS + 3;
    localparam int LAST = NREG - 1;

    wsh_pkg::axis_stage_t pipe_reg  [NREG];
    wsh_pkg::axis_stage_t pipe_next [NREG];
    logic [wsh_pkg::DIM_W-1:0] res_reg;
    logic [wsh_pkg::DIM_W-1:0] res_next;

    // Stage logic
    always_comb
    begin
        logic [wsh_pkg::DIM_W+1:0] diff;
        logic [wsh_pkg::DIM_W-1:0] v1;
        logic [wsh_pkg::DIM_W-1:0] v2;
        logic [wsh_pkg::DIM_W:0]   trial;
        logic [wsh_pkg::DIM_W-1:0] adj;
        wsh_pkg::axis_stage_t      t;

        // entry: remove decoration, clamp to 1, min, max
        diff = {2'b00, frame} - {{(wsh_pkg::DIM_W+2-wsh_pkg::DECO_W){1'b0}}, deco};
        if (diff[wsh_pkg::DIM_W+1] || (diff == '0))
            v1 = wsh_pkg::DIM_W'(1);
        else
            v1 = diff[wsh_pkg::DIM_W-1:0];
        v2 = (v1 < mn) ? mn : v1;
        t      = '0;
        t.v    = ((mx != '0) && (v2 > mx)) ? mx : v2;
        t.mn   = mn;
        t.mx   = mx;
        t.step = step;
        t.base = base;
        t.deco = deco;
        pipe_next[0] = t;

        // size above base, loaded into the divider
        t     = pipe_reg[0];
        t.r   = (t.v > t.base) ? (t.v - t.base) : '0;
        t.dvd = t.r;
        t.rem = '0;
        pipe_next[1] = t;

        // restoring divider, one bit per stage
        for (int k = 0; k < wsh_pkg::DIV_STEPS; k++)
        begin
            t     = pipe_reg[k+1];
            trial = {t.rem, t.dvd[wsh_pkg::DIM_W-1]};
            if (trial >= {1'b0, t.step})
                trial = trial - {1'b0, t.step};
            t.rem = trial[wsh_pkg::DIM_W-1:0];
            t.dvd = {t.dvd[wsh_pkg::DIM_W-2:0], 1'b0};
            pipe_next[k+2] = t;
        end

        // round up to a whole number of steps
        t   = pipe_reg[LAST-1];
        adj = (t.rem != '0) ? (t.step - t.rem) : '0;
        t.s = {2'b00, t.base} + {2'b00, t.r} + {2'b00, adj};
        pipe_next[LAST] = t;
    end

    // Output: step down past max, add decoration, saturate
    always_comb
    begin
        logic [wsh_pkg::SUM_W:0]   down;
        logic [wsh_pkg::SUM_W-1:0] sel;
        logic [wsh_pkg::SUM_W:0]   sum;
        wsh_pkg::axis_stage_t      t;

        t    = pipe_reg[LAST];
        down = {1'b0, t.s} - {3'b000, t.step};
        if (t.step <= wsh_pkg::DIM_W'(1))
            sel = {2'b00, t.v};
        else if ((t.mx != '0) && (t.s > {2'b00, t.mx}))
        begin
            if (!down[wsh_pkg::SUM_W] && (down[wsh_pkg::SUM_W-1:0] >= {2'b00, t.mn}))
                sel = down[wsh_pkg::SUM_W-1:0];
            else
                sel = {2'b00, t.mn};
        end
        else
            sel = t.s;
        sum = {1'b0, sel} + {{(wsh_pkg::SUM_W+1-wsh_pkg::DECO_W){1'b0}}, t.deco};
        if (sum[wsh_pkg::SUM_W:wsh_pkg::DIM_W] != '0)
            res_next = '1;
        else
            res_next = sum[wsh_pkg::DIM_W-1:0];
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NREG; i++)
                pipe_reg[i] <= pipe_next[i];
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

/* hw/rtl/window_size_hint_fit_top.sv */
// Top level of the window size-hint fit: APB config, valid pipeline and two axis datapaths.
// Pipeline: clamp, offset, 16 divider stages set by the one-bit-per-stage remainder unit,
// round-up sum and output register.
// Throughput: one transaction per cycle unless an output stall freezes the whole pipeline.
// Reset: rst_n clears all valid bits and sets border_reg to 1; payload is not reset.
module window_size_hint_fit_top
#(
    parameter int TITLEBAR_HEIGHT = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] frame_width,
    input  logic [15:0] frame_height,
    input  logic [15:0] min_width,
    input  logic [15:0] min_height,
    input  logic [15:0] max_width,
    input  logic [15:0] max_height,
    input  logic [15:0] width_step,
    input  logic [15:0] height_step,
    input  logic [15:0] base_width,
    input  logic [15:0] base_height,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] fitted_width,
    output logic [15:0] fitted_height
);

    logic [7:0]                       border_reg;
    logic [wsh_pkg::PIPE_DEPTH-1:0]   vld_reg;
    logic                             en;
    logic [wsh_pkg::DECO_W-1:0]       deco_w;
    logic [wsh_pkg::DECO_W-1:0]       deco_h;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            border_reg <= 8'd1;
        else if (psel && penable && pwrite && pready && !paddr[2])
            border_reg <= pwdata[7:0];
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, border_reg};

    // Pipeline advance and valid bits
    assign en       = !(vld_reg[wsh_pkg::PIPE_DEPTH-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[wsh_pkg::PIPE_DEPTH-2:0], in_valid};
    end

    assign out_valid = vld_reg[wsh_pkg::PIPE_DEPTH-1];

    // Decoration per axis
    assign deco_w = {1'b0, border_reg, 1'b0};
    assign deco_h = {2'b00, 8'(TITLEBAR_HEIGHT)} + {2'b00, border_reg};

    wsh_axis u_axis_w
    (
        .clk    (clk),
        .en     (en),
        .frame  (frame_width),
        .deco   (deco_w),
        .mn     (min_width),
        .mx     (max_width),
        .step   (width_step),
        .base   (base_width),
        .result (fitted_width)
    );

    wsh_axis u_axis_h
    (
        .clk    (clk),
        .en     (en),
        .frame  (frame_height),
        .deco   (deco_h),
        .mn     (min_height),
        .mx     (max_height),
        .step   (height_step),
        .base   (base_height),
        .result (fitted_height)
    );

endmodule

/* tb/window_size_hint_fit_top_test.sv */
// Testbench for the window size-hint fit block: APB border setup, random traffic, scoreboard check.
module window_size_hint_fit_top_test;

    localparam int TITLE_H   = 24;
    localparam int LATENCY   = 20;
    localparam int WDOG_MAX  = 4000;
    localparam logic [2:0] REG_BORDER = 3'd0;

    typedef struct {
        logic [15:0] fw, fh, mnw, mnh, mxw, mxh, stw, sth, bw, bh;
    } size_req_t;

    typedef struct {
        logic [15:0] w, h;
    } fitted_t;

    // Scoreboard: predicts fitted sizes and checks them in order
    class fit_scoreboard;
        fitted_t   pending[$];
        int        errors;
        int        checked;
        logic [7:0] border;

        function new();
            errors  = 0;
            checked = 0;
            border  = 8'd1;
        endfunction

        function longint fit_one(longint frame, longint deco, longint mn, longint mx,
                                 longint step, longint base);
            longint v;
            longint r;
            longint s;
            v = frame - deco;
            if (v < 1) v = 1;
            if (v < mn) v = mn;
            if (mx > 0 && v > mx) v = mx;
            if (step > 1)
            begin
                r = v - base;
                if (r < 0) r = 0;
                s = base + ((r + step - 1) / step) * step;
                if (mx > 0 && s > mx)
                    s = (s - step >= mn) ? s - step : mn;
                v = s;
            end
            v += deco;
            if (v > 65535) v = 65535;
            if (v < 0) v = 0;
            return v;
        endfunction

        function void note_request(size_req_t q);
            fitted_t e;
            e.w = 16'(fit_one(q.fw, 2 * border, q.mnw, q.mxw, q.stw, q.bw));
            e.h = 16'(fit_one(q.fh, TITLE_H + border, q.mnh, q.mxh, q.sth, q.bh));
            pending.push_back(e);
        endfunction

        function void check_result(logic [15:0] w, logic [15:0] h);
            fitted_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result w=%0d h=%0d", $time, w, h);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (w !== e.w)
            begin
                $display("%0t: fitted_width expected %0d actual %0d", $time, e.w, w);
                errors++;
            end
            if (h !== e.h)
            begin
                $display("%0t: fitted_height expected %0d actual %0d", $time, e.h, h);
                errors++;
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        in_valid, in_stall, out_valid, out_stall;
    logic [15:0] frame_width, frame_height, min_width, min_height, max_width, max_height;
    logic [15:0] width_step, height_step, base_width, base_height;
    logic [15:0] fitted_width, fitted_height;

    fit_scoreboard sb;
    int  idle_pct;
    int  quiet_cycles;
    int  sent;

    window_size_hint_fit_top dut (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Output side: random stall, check every accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(fitted_width, fitted_height);
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WDOG_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] a, logic [31:0] d);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.border = d[7:0];
    endtask

    function automatic logic [15:0] rand_dim(bit nonzero);
        logic [15:0] v;
        case ($urandom_range(5))
            0: v = 16'hFFFF;
            1: v = 16'($urandom_range(3));
            2: v = 16'($urandom_range(40));
            3: v = 16'($urandom_range(2000));
            default: v = 16'($urandom);
        endcase
        if (nonzero && v == 0) v = 1;
        return v;
    endfunction

    function automatic size_req_t rand_req();
        size_req_t q;
        q.fw  = rand_dim(0);
        q.fh  = rand_dim(0);
        q.mnw = rand_dim(1);
        q.mnh = rand_dim(1);
        q.mxw = ($urandom_range(3) == 0) ? 16'd0 : rand_dim(0);
        q.mxh = ($urandom_range(3) == 0) ? 16'd0 : rand_dim(0);
        q.stw = ($urandom_range(3) == 0) ? 16'd1 : rand_dim(1);
        q.sth = ($urandom_range(3) == 0) ? 16'd1 : rand_dim(1);
        q.bw  = rand_dim(0);
        q.bh  = rand_dim(0);
        return q;
    endfunction

    // Send one request, with random idle cycles before it; valid stays high
    // after the accepting edge so the next request can follow with no gap
    task automatic send_req(size_req_t q);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid     <= 1;
        frame_width  <= q.fw;  frame_height <= q.fh;
        min_width    <= q.mnw; min_height   <= q.mnh;
        max_width    <= q.mxw; max_height   <= q.mxh;
        width_step   <= q.stw; height_step  <= q.sth;
        base_width   <= q.bw;  base_height  <= q.bh;
        sb.note_request(q);
        sent++;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    initial
    begin
        size_req_t q;
        logic [7:0] borders[4];
        sb = new();
        sent = 0; quiet_cycles = 0; idle_pct = 38;
        rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_valid = 0; out_stall = 0;
        {frame_width, frame_height, min_width, min_height, max_width} = '0;
        {max_height, width_step, height_step, base_width, base_height} = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // Directed cases at reset border: tiny frame, max under min, base above size,
        // step-down under min, saturation, all-ones and minimal fields
        q = '{0, 0, 1, 1, 0, 0, 1, 1, 0, 0};                    send_req(q);
        q = '{16'hFFFF, 16'hFFFF, 1, 1, 0, 0, 1, 1, 0, 0};      send_req(q);
        q = '{100, 100, 200, 200, 50, 50, 1, 1, 0, 0};          send_req(q);
        q = '{100, 100, 1, 1, 0, 0, 7, 9, 500, 600};            send_req(q);
        q = '{100, 100, 40, 40, 45, 45, 10, 10, 0, 0};          send_req(q);
        q = '{100, 100, 44, 44, 45, 45, 10, 10, 0, 0};          send_req(q);
        q = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};           send_req(q);
        q = '{300, 300, 1, 1, 0, 0, 16'hFFFF, 16'hFFFF, 3, 3};  send_req(q);
        q = '{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 0, 0, 2, 3, 1, 2}; send_req(q);
        drain();

        // Random phases over several border settings, extremes included
        borders = '{8'd0, 8'd255, 8'd1, 8'd0};
        borders[3] = 8'($urandom_range(2, 254));
        for (int p = 0; p < 4; p++)
        begin
            apb_write(REG_BORDER, {24'd0, borders[p]});
            for (int i = 0; i < 385; i++)
            begin
                // one stretch with no idling on either side
                idle_pct = (p == 2 && i < 150) ? 0 : 38;
                send_req(rand_req());
            end
            drain();
        end

        $display("Sent %0d requests over border sizes 1, 0, 255, 1 and %0d; %0d results checked",
                 sent, borders[3], sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
